// ===== hw/rtl/bfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, constants and the byte-wide crc32 update for the binary
// frame sync and crc32 checker.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int FRAME_MAX_BYTES = 4096;

  localparam int POS_W = 17;
  localparam int SUM_W = POS_W + 1;

  localparam logic [7:0] SYNC_BYTE0 = 8'hAA;
  localparam logic [7:0] SYNC_BYTE1 = 8'h44;
  localparam logic [7:0] SYNC_BYTE2 = 8'h12;

  localparam logic [7:0] HDR_LEN_MIN = 8'd10;

  // header byte positions
  localparam logic [POS_W-1:0] POS_HDR_LEN = 17'd3;
  localparam logic [POS_W-1:0] POS_ID_LO   = 17'd4;
  localparam logic [POS_W-1:0] POS_ID_HI   = 17'd5;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd8;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd9;

  localparam logic [SUM_W-1:0] TRAILER_BYTES = 18'd4;
  localparam logic [SUM_W-1:0] FRAME_MAX     = SUM_W'(FRAME_MAX_BYTES);

  localparam logic [31:0] POLY_RESET    = 32'hEDB88320;
  localparam logic [7:0]  HDR_LEN_RESET = 8'd28;

  typedef enum logic [0:0] {
    CFG_CRC_POLY = 1'b0,
    CFG_HDR_LEN  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  // reflected crc32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                           input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] x;
    x = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (x[0]) begin
        x = (x >> 1) ^ poly;
      end else begin
        x = x >> 1;
      end
    end
    return {8'd0, crc[31:8]} ^ x;
  endfunction

  // crc after the first two sync bytes with the reset polynomial
  localparam logic [31:0] SYNC_CRC2_RESET =
    crc_byte(crc_byte(32'd0, SYNC_BYTE0, POLY_RESET), SYNC_BYTE1, POLY_RESET);

endpackage

// ===== hw/rtl/binary_frame_sync_crc32_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_frame_sync_crc32_checker
// Hunts for AA 44 12 in a byte stream, parses the header, checks the trailing
// crc32 and reports one item per completed frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per item, valid/stall handshake.
//   out_* : one item per completed frame (message id, payload length, crc_ok).
//   cfg_* : write port; index 0 is the crc polynomial, index 1 the expected
//           header length. Writes take effect for bytes accepted from the
//           same clock edge on.
// Each byte goes into an input register and is processed once the result
// register is free; a frame's result is registered when its last trailer
// byte is processed. One byte is taken every cycle while in_stall is low;
// the per-byte crc update is a single eight-bit unrolled step against the
// polynomial register. While a result is held by out_stall, the input
// register keeps its byte and in_stall rises only once that register is full,
// so one more byte is still taken. Reset (rst_n low, synchronous) empties
// both registers, restores the register defaults and restarts the sync hunt.
// ----------------------------------------------------------------------------
module binary_frame_sync_crc32_checker
  import bfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_message_id,
  output logic [15:0] out_payload_length,
  output logic        out_crc_ok,

  input  logic        cfg_we,
  input  cfg_index_t  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // configuration
  logic [31:0] poly_r, poly_nxt;
  logic [7:0]  hdr_len_r, hdr_len_nxt;
  logic [31:0] sync_crc2_r;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;

  // frame state
  phase_t           phase_r, phase_nxt;
  logic [1:0]       sync_r, sync_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [31:0]      rcv_r, rcv_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_id_r;
  logic [15:0] out_len_r;
  logic        out_ok_r;

  logic              out_free, in_accept, fire;
  logic [7:0]        b;
  logic [31:0]       crc_upd, sync_crc3;
  logic [SUM_W-1:0]  p_inc, frame_end, hdr_ext, frame_size;
  logic [15:0]       len_new;
  logic              hdr_bad, oversize, drop, hdr_done, pay_done, trl_done;
  logic              sync_hit;

  // ---------------------------------------------------------------- handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign fire      = s1_valid_r && out_free;
  assign b         = s1_byte_r;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // ---------------------------------------------------------------- config
  always_comb begin
    poly_nxt    = poly_r;
    hdr_len_nxt = hdr_len_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CRC_POLY: poly_nxt    = cfg_wdata;
        CFG_HDR_LEN:  hdr_len_nxt = cfg_wdata[7:0];
        default:      poly_nxt    = poly_r;
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  assign crc_upd   = crc_byte(crc_r, b, poly_r);
  assign sync_crc3 = crc_byte(sync_crc2_r, SYNC_BYTE2, poly_r);

  assign p_inc     = {1'b0, pos_r} + 18'd1;
  assign hdr_ext   = {10'd0, hdr_len_r};
  assign frame_end = hdr_ext + {2'd0, len_r};

  assign len_new    = (pos_r == POS_LEN_LO) ? {len_r[15:8], b} :
                      (pos_r == POS_LEN_HI) ? {b, len_r[7:0]} : len_r;
  assign frame_size = hdr_ext + {2'd0, len_new} + TRAILER_BYTES;

  assign hdr_bad  = (pos_r == POS_HDR_LEN) && ((b != hdr_len_r) || (hdr_len_r < HDR_LEN_MIN));
  assign oversize = (pos_r == POS_LEN_HI) && (frame_size > FRAME_MAX);
  assign drop     = hdr_bad || oversize;
  assign hdr_done = (pos_r >= POS_LEN_HI) && (p_inc >= hdr_ext);
  assign pay_done = (p_inc >= frame_end) || p_inc[SUM_W-1];
  assign trl_done = p_inc >= TRAILER_BYTES;

  assign sync_hit = (sync_r == 2'd2) && (b == SYNC_BYTE2);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (sync_hit) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (drop) begin
            phase_nxt = PH_HUNT;
          end else if (hdr_done) begin
            phase_nxt = (len_new == 16'd0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_done) begin
            phase_nxt = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          if (trl_done) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // next frame registers and result
  always_comb begin
    sync_nxt      = sync_r;
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    id_nxt        = id_r;
    len_nxt       = len_r;
    rcv_nxt       = rcv_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    if (fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          if ((sync_r == 2'd1) && (b == SYNC_BYTE1)) begin
            sync_nxt = 2'd2;
          end else if (sync_hit) begin
            sync_nxt = 2'd0;
            pos_nxt  = POS_HDR_LEN;
            crc_nxt  = sync_crc3;
            id_nxt   = 16'd0;
            len_nxt  = 16'd0;
            rcv_nxt  = 32'd0;
          end else if (b == SYNC_BYTE0) begin
            sync_nxt = 2'd1;
          end else begin
            sync_nxt = 2'd0;
          end
        end
        PH_HEADER: begin
          crc_nxt = crc_upd;
          len_nxt = len_new;
          if (pos_r == POS_ID_LO) begin
            id_nxt = {id_r[15:8], b};
          end else if (pos_r == POS_ID_HI) begin
            id_nxt = {b, id_r[7:0]};
          end
          if (drop) begin
            // resync: the dropping byte is looked at as a hunt byte
            pos_nxt  = '0;
            sync_nxt = (b == SYNC_BYTE0) ? 2'd1 : 2'd0;
          end else if (hdr_done && (len_new == 16'd0)) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = p_inc[POS_W-1:0];
          end
        end
        PH_PAYLOAD: begin
          crc_nxt = crc_upd;
          pos_nxt = pay_done ? '0 : p_inc[POS_W-1:0];
        end
        PH_TRAILER: begin
          case (pos_r[1:0])
            2'd0:    rcv_nxt = rcv_r | {24'd0, b};
            2'd1:    rcv_nxt = rcv_r | {16'd0, b, 8'd0};
            2'd2:    rcv_nxt = rcv_r | {8'd0, b, 16'd0};
            default: rcv_nxt = rcv_r | {b, 24'd0};
          endcase
          if (trl_done) begin
            pos_nxt       = '0;
            sync_nxt      = 2'd0;
            out_valid_nxt = 1'b1;
          end else begin
            pos_nxt = p_inc[POS_W-1:0];
          end
        end
        default: sync_nxt = 2'd0;
      endcase
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= POLY_RESET;
      hdr_len_r   <= HDR_LEN_RESET;
      sync_crc2_r <= SYNC_CRC2_RESET;
      s1_valid_r  <= 1'b0;
      phase_r     <= PH_HUNT;
      sync_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      poly_r      <= poly_nxt;
      hdr_len_r   <= hdr_len_nxt;
      // crc of the first two sync bytes, kept in step with the polynomial
      sync_crc2_r <= crc_byte(crc_byte(32'd0, SYNC_BYTE0, poly_nxt), SYNC_BYTE1, poly_nxt);
      s1_valid_r  <= s1_valid_nxt;
      phase_r     <= phase_nxt;
      sync_r      <= sync_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_byte;
    end
    pos_r <= pos_nxt;
    crc_r <= crc_nxt;
    id_r  <= id_nxt;
    len_r <= len_nxt;
    rcv_r <= rcv_nxt;
    if (fire && (phase_r == PH_TRAILER) && trl_done) begin
      out_id_r  <= id_r;
      out_len_r <= len_r;
      out_ok_r  <= (rcv_nxt == crc_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_message_id     = out_id_r;
  assign out_payload_length = out_len_r;
  assign out_crc_ok         = out_ok_r;

endmodule
